>>> sv/mexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Word types for the operand and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

    // Operand word: base, exponent and modulus, unsigned
    typedef struct packed {
        logic [63:0] base_value;
        logic [63:0] exponent_value;
        logic [63:0] modulus_value;
    } t_in_word;

    // Result word: power and zero-modulus flag
    typedef struct packed {
        logic [63:0] power_result;
        logic        bad_modulus;
    } t_out_word;

endpackage

`default_nettype wire

>>> sv/modular_exponentiation_top.sv
// ----------------------------------------------------------------------------
// Modular exponentiation top level
// Right-to-left square-and-multiply over one bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// Computes base^exponent mod modulus on the low WIDTH bits of each operand
// word, one word at a time. A zero modulus returns 0 with bad_modulus set, a
// zero exponent returns 1 (not reduced); both go from acceptance through the
// done state to the output register, which loads once it is free. Otherwise
// the base is first reduced, then each exponent bit up to the highest set
// one passes the step state and then runs modular multiplications: a squaring
// for every bit but the top one and a multiply for each set bit. All
// multiplications run on the single shared multiply unit, which consumes one
// multiplier bit per cycle as a doubling plus conditional add reduced modulo
// the modulus. A new operand word is taken the cycle after the previous
// result has been handed to the output register, which may still be waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_top #(
    parameter int WIDTH = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire mexp_pkg::t_in_word i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output mexp_pkg::t_out_word  o_out_data
);

    localparam int CNT_W = $clog2(WIDTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_STEP,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_RED,
        OP_ACC,
        OP_SQR
    } t_op;

    t_state              r_state;
    t_op                 r_op;
    logic [WIDTH-1:0]    r_mod;
    logic [WIDTH-1:0]    r_exp;
    logic [WIDTH-1:0]    r_acc;
    logic [WIDTH-1:0]    r_pow;
    logic                r_bad;
    logic [WIDTH-1:0]    r_prod;
    logic [WIDTH-1:0]    r_mcand;
    logic [WIDTH-1:0]    r_mplier;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_out_valid;
    mexp_pkg::t_out_word r_out_data;

    logic [WIDTH-1:0]    in_base;
    logic [WIDTH-1:0]    in_exp;
    logic [WIDTH-1:0]    in_mod;
    logic [WIDTH-1:0]    in_unit;
    logic [WIDTH-1:0]    mod_unit;
    logic [WIDTH+1:0]    mul_sum;
    logic [WIDTH+2:0]    mul_d1;
    logic [WIDTH+2:0]    mul_d2;
    logic [WIDTH-1:0]    n_prod;
    logic                out_free;

    assign in_base  = i_in_data.base_value[WIDTH-1:0];
    assign in_exp   = i_in_data.exponent_value[WIDTH-1:0];
    assign in_mod   = i_in_data.modulus_value[WIDTH-1:0];

    // One reduced modulo the modulus: zero when the modulus is one
    assign in_unit  = (in_mod == WIDTH'(1)) ? '0 : WIDTH'(1);
    assign mod_unit = (r_mod == WIDTH'(1)) ? '0 : WIDTH'(1);

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Multiply step: prod = (2*prod + bit*mcand) mod modulus, operands below modulus
    always_comb begin
        mul_sum = {1'b0, r_prod, 1'b0} + (r_mplier[WIDTH-1] ? {2'b0, r_mcand} : '0);
        mul_d1  = {1'b0, mul_sum} - {3'b0, r_mod};
        mul_d2  = {1'b0, mul_sum} - {2'b0, r_mod, 1'b0};
        if (!mul_d2[WIDTH+2]) begin
            n_prod = mul_d2[WIDTH-1:0];
        end else if (!mul_d1[WIDTH+2]) begin
            n_prod = mul_d1[WIDTH-1:0];
        end else begin
            n_prod = mul_sum[WIDTH-1:0];
        end
    end

    // Sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_RED;
            r_acc       <= '0;
            r_pow       <= '0;
            r_exp       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the output word once taken, unless a new one replaces it
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mod <= in_mod;
                        r_exp <= in_exp;
                        if (in_mod == '0) begin
                            r_acc   <= '0;
                            r_bad   <= 1'b1;
                            r_state <= S_DONE;
                        end else if (in_exp == '0) begin
                            r_acc   <= WIDTH'(1);
                            r_bad   <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            // Reduce the base: multiply by one mod modulus
                            r_bad    <= 1'b0;
                            r_prod   <= '0;
                            r_mcand  <= in_unit;
                            r_mplier <= in_base;
                            r_cnt    <= CNT_W'(WIDTH - 1);
                            r_op     <= OP_RED;
                            r_state  <= S_MUL;
                        end
                    end
                end

                S_MUL: begin
                    if (r_cnt == '0) begin
                        case (r_op)
                            OP_RED: begin
                                r_pow   <= n_prod;
                                r_acc   <= mod_unit;
                                r_state <= S_STEP;
                            end
                            OP_ACC: begin
                                r_acc <= n_prod;
                                if (r_exp[WIDTH-1:1] == '0) begin
                                    // Top bit done: skip the final squaring
                                    r_exp   <= '0;
                                    r_state <= S_STEP;
                                end else begin
                                    r_prod   <= '0;
                                    r_mcand  <= r_pow;
                                    r_mplier <= r_pow;
                                    r_cnt    <= CNT_W'(WIDTH - 1);
                                    r_op     <= OP_SQR;
                                end
                            end
                            OP_SQR: begin
                                r_pow   <= n_prod;
                                r_exp   <= {1'b0, r_exp[WIDTH-1:1]};
                                r_state <= S_STEP;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end else begin
                        // Advance one multiplier bit
                        r_prod   <= n_prod;
                        r_mplier <= {r_mplier[WIDTH-2:0], 1'b0};
                        r_cnt    <= r_cnt - CNT_W'(1);
                    end
                end

                S_STEP: begin
                    // Scan the next exponent bit
                    r_prod <= '0;
                    r_cnt  <= CNT_W'(WIDTH - 1);
                    if (r_exp == '0) begin
                        r_state <= S_DONE;
                    end else if (r_exp[0]) begin
                        r_mcand  <= r_acc;
                        r_mplier <= r_pow;
                        r_op     <= OP_ACC;
                        r_state  <= S_MUL;
                    end else begin
                        r_mcand  <= r_pow;
                        r_mplier <= r_pow;
                        r_op     <= OP_SQR;
                        r_state  <= S_MUL;
                    end
                end

                S_DONE: begin
                    // Hold until the output register is free
                    if (out_free) begin
                        r_out_valid              <= 1'b1;
                        r_out_data.power_result  <= 64'(r_acc);
                        r_out_data.bad_modulus   <= r_bad;
                        r_state                  <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Partial product and multiplicand stay reduced during a multiplication
    a_prod_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_prod < r_mod && r_mcand < r_mod))
        else $error("multiplier operand not reduced");

    // A flagged result carries a zero power
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.bad_modulus) |-> (o_out_data.power_result == '0))
        else $error("bad modulus with nonzero power");

    // A word with nonzero modulus and exponent starts a base reduction
    a_start_reduce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && in_mod != '0 && in_exp != '0)
        |=> (r_state == S_MUL && r_op == OP_RED))
        else $error("accepted word did not start reduction");

endmodule

`default_nettype wire
